// ===== hw/rtl/dgds_pkg.sv =====
// Shared types, constants and stencil coefficients for the DG diffusion stencil.
`timescale 1ns / 1ps
`default_nettype none
package dgds_pkg;

  localparam int CELL_COEFFS = 2;
  // Three cells (left, centre, right) times the coefficients of each cell.
  localparam int TERMS = 3 * CELL_COEFFS;
  localparam int TERM_W = $clog2(TERMS);
  localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(TERMS - 1);

  localparam int COEF_W = 32;
  // Exact stencil sum of integer coefficients times Q16.16 values.
  localparam int ACC_W = 42;
  // Product magnitude after dropping 24 fraction bits.
  localparam int MAG_W = 51;
  // Signed value before saturation.
  localparam int VAL_W = 53;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCHEME = 2'd0;
  localparam logic [1:0] CFG_GAIN = 2'd1;
  localparam logic [1:0] CFG_ONLY_INC = 2'd2;

  // Stencil entries scaled by 4*dx^2, indexed [scheme][output row][term].
  // Terms run lower mean, lower slope, centre mean, centre slope, upper mean, upper slope.
  localparam logic signed [7:0] STENCIL [4][CELL_COEFFS][TERMS] = '{
    '{'{8'sd16, 8'sd8, -8'sd32, 8'sd8, 8'sd16, -8'sd16},
      '{-8'sd48, -8'sd24, 8'sd24, -8'sd96, 8'sd24, -8'sd24}},
    '{'{8'sd16, 8'sd16, -8'sd32, -8'sd8, 8'sd16, -8'sd8},
      '{-8'sd24, -8'sd24, -8'sd24, -8'sd96, 8'sd48, -8'sd24}},
    '{'{8'sd16, 8'sd12, -8'sd32, 8'sd0, 8'sd16, -8'sd12},
      '{-8'sd36, -8'sd24, 8'sd0, -8'sd96, 8'sd36, -8'sd24}},
    '{'{8'sd9, 8'sd5, -8'sd18, 8'sd0, 8'sd9, -8'sd5},
      '{-8'sd15, -8'sd7, 8'sd0, -8'sd46, 8'sd15, -8'sd7}}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMBINE,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              acc_en;
    logic [TERM_W-1:0] term;
    logic              row;
    logic              abs_en;
    logic              mul_lo;
    logic              mul_hi;
    logic              combine;
    logic              finish;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dg_diffusion_stencil_1d.sv =====
// Top level of the one-dimensional DG diffusion stencil with its configuration registers.
//
// Cells of a line arrive on the input channel (in_valid, in_stall, coef_mean, coef_slope,
// line_start), ghost cells included; line_start marks the first cell of a line and empties
// the three-cell window. The first two cells of a line only fill the window and give no
// result. Every later cell gives one result on the output channel (out_valid, out_stall,
// res_mean, res_slope) for the cell before it. Such a cell keeps the block busy: per
// output coefficient, the stencil multiply-accumulate over the six terms, then the shared
// 32x32 gain multiplier, rounding and saturation, and after both coefficients the load of
// the output register. The next cell is taken only once the result is loaded. The output
// register holds a result while out_stall is high; the block still takes non-producing
// cells and finishes the next result, then waits until the register frees. Configuration
// registers (scheme, gain, only_increment) are written through cfg_write_en, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the block does
// not enforce. Index 3 is ignored. The synchronous reset clears the registers, the window
// fill count and both channels.
`timescale 1ns / 1ps
`default_nettype none
module dg_diffusion_stencil_1d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [1:0]                          cfg_index,
  input  logic [dgds_pkg::COEF_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dgds_pkg::COEF_W-1:0]  coef_mean,
  input  logic signed [dgds_pkg::COEF_W-1:0]  coef_slope,
  input  logic                                line_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dgds_pkg::COEF_W-1:0]  res_mean,
  output logic signed [dgds_pkg::COEF_W-1:0]  res_slope
);

  logic [1:0] scheme;
  logic signed [dgds_pkg::COEF_W-1:0] gain;
  logic only_increment;
  dgds_pkg::cmd_t cmd;
  dgds_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme <= '0;
      gain <= '0;
      only_increment <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        dgds_pkg::CFG_SCHEME:   scheme <= cfg_data[1:0];
        dgds_pkg::CFG_GAIN:     gain <= $signed(cfg_data);
        dgds_pkg::CFG_ONLY_INC: only_increment <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dgds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dgds_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .scheme         (scheme),
    .gain           (gain),
    .only_increment (only_increment),
    .coef_mean      (coef_mean),
    .coef_slope     (coef_slope),
    .line_start     (line_start),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .res_mean       (res_mean),
    .res_slope      (res_slope)
  );

  // A cell that only fills the window leaves the input side open in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !status.produce) |=> !in_stall)
    else $error("input closed after a window-fill transfer");

  // A cell that yields a result occupies the block.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && status.produce) |=> in_stall)
    else $error("input open while a result is computed");

  // The output register only becomes valid through a load from the controller.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a load");

  // A load never overwrites a result that is still held by a stalled receiver.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("held result overwritten");

endmodule
`default_nettype wire

// ===== hw/rtl/dgds_ctrl.sv =====
// Controller state machine that sequences the stencil datapath for one cell.
`timescale 1ns / 1ps
`default_nettype none
module dgds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dgds_pkg::status_t  status,
  output dgds_pkg::cmd_t     cmd
);

  dgds_pkg::state_t state, state_next;
  logic [dgds_pkg::TERM_W-1:0] term, term_next;
  logic row, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgds_pkg::ST_IDLE;
      term <= '0;
      row <= 1'b0;
    end else begin
      state <= state_next;
      term <= term_next;
      row <= row_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next = term;
    row_next = row;
    case (state)
      dgds_pkg::ST_IDLE: begin
        if (in_valid && status.produce) begin
          state_next = dgds_pkg::ST_ACC;
          term_next = '0;
          row_next = 1'b0;
        end
      end
      dgds_pkg::ST_ACC: begin
        if (term == dgds_pkg::LAST_TERM) begin
          term_next = '0;
          state_next = dgds_pkg::ST_ABS;
        end else begin
          term_next = term + 1'b1;
        end
      end
      dgds_pkg::ST_ABS:     state_next = dgds_pkg::ST_MUL_LO;
      dgds_pkg::ST_MUL_LO:  state_next = dgds_pkg::ST_MUL_HI;
      dgds_pkg::ST_MUL_HI:  state_next = dgds_pkg::ST_COMBINE;
      dgds_pkg::ST_COMBINE: state_next = dgds_pkg::ST_FINISH;
      dgds_pkg::ST_FINISH: begin
        if (row) begin
          row_next = 1'b0;
          state_next = dgds_pkg::ST_OUTPUT;
        end else begin
          row_next = 1'b1;
          state_next = dgds_pkg::ST_ACC;
        end
      end
      dgds_pkg::ST_OUTPUT: begin
        if (!status.out_full) begin
          state_next = dgds_pkg::ST_IDLE;
        end
      end
      default: state_next = dgds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.term = term;
    cmd.row = row;
    in_stall = 1'b1;
    case (state)
      dgds_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      dgds_pkg::ST_ACC:     cmd.acc_en = 1'b1;
      dgds_pkg::ST_ABS:     cmd.abs_en = 1'b1;
      dgds_pkg::ST_MUL_LO:  cmd.mul_lo = 1'b1;
      dgds_pkg::ST_MUL_HI:  cmd.mul_hi = 1'b1;
      dgds_pkg::ST_COMBINE: cmd.combine = 1'b1;
      dgds_pkg::ST_FINISH:  cmd.finish = 1'b1;
      dgds_pkg::ST_OUTPUT:  cmd.out_load = !status.out_full;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dgds_datapath.sv =====
// Datapath: cell window, stencil accumulator, shared gain multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none
module dgds_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dgds_pkg::cmd_t                      cmd,
  output dgds_pkg::status_t                   status,
  input  logic [1:0]                          scheme,
  input  logic signed [dgds_pkg::COEF_W-1:0]  gain,
  input  logic                                only_increment,
  input  logic signed [dgds_pkg::COEF_W-1:0]  coef_mean,
  input  logic signed [dgds_pkg::COEF_W-1:0]  coef_slope,
  input  logic                                line_start,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [dgds_pkg::COEF_W-1:0]  res_mean,
  output logic signed [dgds_pkg::COEF_W-1:0]  res_slope
);

  localparam int CW = dgds_pkg::COEF_W;
  localparam int AW = dgds_pkg::ACC_W;
  localparam int MW = dgds_pkg::MAG_W;
  localparam int VW = dgds_pkg::VAL_W;
  localparam int PW = CW + 8;
  localparam logic signed [VW-1:0] V_MAX = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [2*CW-1:0] ROUND_HALF = (2*CW)'(64'h80_0000);

  logic signed [CW-1:0] win_mean [2];
  logic signed [CW-1:0] win_slope [2];
  logic [1:0] fill_count;
  logic [1:0] fill_eff;
  logic signed [CW-1:0] work_mean [3];
  logic signed [CW-1:0] work_slope [3];

  logic signed [CW-1:0] operand;
  logic signed [7:0] coef;
  logic signed [PW-1:0] term_prod;
  logic signed [AW-1:0] acc;

  logic [CW-1:0] a_mag;
  logic [AW-1:0] b_mag;
  logic neg;
  logic [CW-1:0] mul_b;
  logic [2*CW-1:0] mul_p;
  logic [2*CW-1:0] plo;
  logic [AW-1:0] phi;
  logic [MW-1:0] lo_rnd;
  logic [MW-1:0] mag;

  logic signed [CW-1:0] center;
  logic signed [VW-1:0] base;
  logic signed [VW-1:0] mag_ext;
  logic signed [VW-1:0] v;
  logic signed [CW-1:0] sat;
  logic signed [CW-1:0] hold_mean;
  logic signed [CW-1:0] hold_slope;

  // A line start empties the window before the arriving cell is taken.
  assign fill_eff = line_start ? 2'd0 : fill_count;

  always_comb begin
    status.produce = (fill_eff == 2'd2);
    status.out_full = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 2'd0;
    end else if (cmd.load && !status.produce) begin
      fill_count <= fill_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (status.produce) begin
        work_mean[0] <= win_mean[0];
        work_mean[1] <= win_mean[1];
        work_mean[2] <= coef_mean;
        work_slope[0] <= win_slope[0];
        work_slope[1] <= win_slope[1];
        work_slope[2] <= coef_slope;
        win_mean[0] <= win_mean[1];
        win_mean[1] <= coef_mean;
        win_slope[0] <= win_slope[1];
        win_slope[1] <= coef_slope;
      end else begin
        if (line_start) begin
          win_mean[1] <= '0;
          win_slope[1] <= '0;
        end
        win_mean[fill_eff[0]] <= coef_mean;
        win_slope[fill_eff[0]] <= coef_slope;
      end
    end
  end

  always_comb begin
    case (cmd.term)
      3'd0:    operand = work_mean[0];
      3'd1:    operand = work_slope[0];
      3'd2:    operand = work_mean[1];
      3'd3:    operand = work_slope[1];
      3'd4:    operand = work_mean[2];
      3'd5:    operand = work_slope[2];
      default: operand = '0;
    endcase
  end

  assign coef = dgds_pkg::STENCIL[scheme][cmd.row][cmd.term];
  assign term_prod = coef * operand;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      if (cmd.term == '0) begin
        acc <= AW'(term_prod);
      end else begin
        acc <= acc + AW'(term_prod);
      end
    end
  end

  // Sign and magnitude form for the gain product; rounding is on the magnitude.
  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      a_mag <= gain[CW-1] ? (~gain + 1'b1) : gain;
      b_mag <= acc[AW-1] ? (~acc + 1'b1) : acc;
      neg <= gain[CW-1] ^ acc[AW-1];
    end
  end

  // One 32x32 multiplier takes the low word of the sum first, then its high bits.
  assign mul_b = cmd.mul_hi ? CW'(b_mag[AW-1:CW]) : b_mag[CW-1:0];
  assign mul_p = a_mag * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      plo <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi <= mul_p[AW-1:0];
      lo_rnd <= MW'((plo + ROUND_HALF) >> 24);
    end
    if (cmd.combine) begin
      mag <= MW'({phi, 8'b0}) + lo_rnd;
    end
  end

  always_comb begin
    center = cmd.row ? work_slope[1] : work_mean[1];
    base = only_increment ? '0 : VW'(center);
    mag_ext = $signed({{(VW-MW){1'b0}}, mag});
    v = neg ? (base - mag_ext) : (base + mag_ext);
    if (v > V_MAX) begin
      sat = V_MAX[CW-1:0];
    end else if (v < V_MIN) begin
      sat = V_MIN[CW-1:0];
    end else begin
      sat = v[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.row) begin
        hold_slope <= sat;
      end else begin
        hold_mean <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_mean <= hold_mean;
      res_slope <= hold_slope;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the DG diffusion stencil: directed table, then random lines.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_CELLS = 190;
  localparam int REPORT_LIMIT = 200;
  localparam int N_ROWS = 28;

  // Stencil matrices times 4*dx^2: [scheme][lower, centre, upper][row][column].
  localparam int STENCIL_X4 [4][3][2][2] = '{
    '{'{'{16, 8}, '{-48, -24}}, '{'{-32, 8}, '{24, -96}}, '{'{16, -16}, '{24, -24}}},
    '{'{'{16, 16}, '{-24, -24}}, '{'{-32, -8}, '{-24, -96}}, '{'{16, -8}, '{48, -24}}},
    '{'{'{16, 12}, '{-36, -24}}, '{'{-32, 0}, '{0, -96}}, '{'{16, -12}, '{36, -24}}},
    '{'{'{9, 5}, '{-15, -7}}, '{'{-18, 0}, '{0, -46}}, '{'{9, -5}, '{15, -7}}}
  };

  typedef struct {
    logic [31:0] mean;
    logic [31:0] slope;
  } coef_pair_t;

  typedef enum logic {ROW_CELL, ROW_CFG} row_kind_t;

  // Cell rows carry mean, slope and line start; config rows carry index and data.
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic        ls;
    bit          typed;
    logic [31:0] em;
    logic [31:0] es;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] coef_mean;
  logic signed [31:0] coef_slope;
  logic line_start;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] res_mean;
  logic signed [31:0] res_slope;

  coef_pair_t pending_results[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  // Predictor state and its copy of the registers.
  logic [31:0] win_mean [2];
  logic [31:0] win_slope [2];
  int win_fill;
  logic [1:0] pred_scheme;
  logic signed [31:0] pred_gain;
  logic pred_only_inc;

  // Cell rows fill the unused index with the scheme index.
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, NEG_MAX, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, NEG_MAX, POS_MAX, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h0, 32'hFFFF_FFFF, 1'b0, 1, NEG_MAX, POS_MAX},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h1, 32'h5555_5555, 1'b0, 1, 32'h0, 32'hFFFF_FFFF},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h7, 32'h9, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h3, 32'h4, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h5, 32'h6, 1'b0, 1, 32'h3, 32'h4},
    '{ROW_CFG, dgds_pkg::CFG_ONLY_INC, 32'hFFFF_FFFF, '0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, POS_MAX, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, POS_MAX, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, POS_MAX, 1'b0, 1, 32'h0, 32'h0},
    '{ROW_CFG, dgds_pkg::CFG_GAIN, POS_MAX, '0, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_SCHEME, 32'hFFFF_FFFD, '0, 1'b0, 0, '0, '0},
    '{ROW_CFG, CFG_UNUSED, 32'hFFFF_FFFF, '0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, NEG_MAX, NEG_MAX, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, POS_MAX, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, NEG_MAX, NEG_MAX, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_SCHEME, 32'h2, '0, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_GAIN, NEG_MAX, '0, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_ONLY_INC, 32'h0, '0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, POS_MAX, NEG_MAX, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_SCHEME, 32'h3, '0, 1'b0, 0, '0, '0},
    '{ROW_CFG, dgds_pkg::CFG_GAIN, 32'h0080_0000, '0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h1, 32'h0, 1'b1, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h0, 32'h0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'h0, 32'h0, 1'b0, 0, '0, '0},
    '{ROW_CELL, dgds_pkg::CFG_SCHEME, 32'hFFFF_FFFF, 32'h0, 1'b0, 0, '0, '0}
  };

  dg_diffusion_stencil_1d uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coef_mean   (coef_mean),
    .coef_slope  (coef_slope),
    .line_start  (line_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res_mean    (res_mean),
    .res_slope   (res_slope)
  );

  // round(g * s / 2^24) with ties away from zero, done on magnitudes.
  function automatic longint scale_by_gain(input longint g, input longint s);
    logic [95:0] mag;
    bit neg;
    neg = (g < 0) != (s < 0);
    mag = 96'(g < 0 ? -g : g) * 96'(s < 0 ? -s : s);
    mag = (mag + 96'h80_0000) >> 24;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return POS_MAX;
    if (v < -64'sd2147483648) return NEG_MAX;
    return v[31:0];
  endfunction

  // Takes one cell into the window; returns 1 when it completes a centre cell.
  function automatic bit stencil_step(input logic [31:0] m, input logic [31:0] s,
                                      input logic ls, output logic [31:0] om,
                                      output logic [31:0] os);
    longint u_mean [3];
    longint u_slope [3];
    longint acc;
    longint val;
    om = '0;
    os = '0;
    if (ls) begin
      win_mean[0] = '0;
      win_mean[1] = '0;
      win_slope[0] = '0;
      win_slope[1] = '0;
      win_fill = 0;
    end
    if (win_fill < 2) begin
      win_mean[win_fill] = m;
      win_slope[win_fill] = s;
      win_fill++;
      return 1'b0;
    end
    u_mean[0] = longint'(signed'(win_mean[0]));
    u_mean[1] = longint'(signed'(win_mean[1]));
    u_mean[2] = longint'(signed'(m));
    u_slope[0] = longint'(signed'(win_slope[0]));
    u_slope[1] = longint'(signed'(win_slope[1]));
    u_slope[2] = longint'(signed'(s));
    for (int r = 0; r < 2; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += STENCIL_X4[pred_scheme][k][r][0] * u_mean[k]
             + STENCIL_X4[pred_scheme][k][r][1] * u_slope[k];
      end
      val = scale_by_gain(longint'(pred_gain), acc);
      if (!pred_only_inc) val += (r == 0) ? u_mean[1] : u_slope[1];
      if (r == 0) om = clamp32(val);
      else os = clamp32(val);
    end
    win_mean[0] = win_mean[1];
    win_slope[0] = win_slope[1];
    win_mean[1] = m;
    win_slope[1] = s;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 2000)) - 32'd1000;
      1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      2: begin
        case ($urandom_range(0, 3))
          0: return POS_MAX;
          1: return NEG_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] phase_gain(input int p);
    case (p)
      0: return POS_MAX;
      1: return NEG_MAX;
      4: return '0;
      5: return 32'h0100_0000;
      3, 7: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cell(input logic [31:0] m, input logic [31:0] s, input logic ls,
                           input bit typed = 0, input logic [31:0] em = '0,
                           input logic [31:0] es = '0);
    logic [31:0] pm;
    logic [31:0] ps;
    coef_pair_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    coef_mean <= m;
    coef_slope <= s;
    line_start <= ls;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (stencil_step(m, s, ls, pm, ps)) begin
      item.mean = typed ? em : pm;
      item.slope = typed ? es : ps;
      pending_results.push_back(item);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      dgds_pkg::CFG_SCHEME: pred_scheme = data[1:0];
      dgds_pkg::CFG_GAIN: pred_gain = data;
      dgds_pkg::CFG_ONLY_INC: pred_only_inc = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  // A cell that gives no result may still be in flight when the queue empties.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    coef_pair_t exp_item;
    forever begin
      @(posedge clk);
      if (rst == 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          if (err_count < REPORT_LIMIT)
            $error("res_mean: expected no transfer, got %0d (res_slope %0d)",
                   res_mean, res_slope);
          err_count++;
        end else begin
          exp_item = pending_results.pop_front();
          if (res_mean !== exp_item.mean) begin
            if (err_count < REPORT_LIMIT)
              $error("res_mean: expected %0d, got %0d", $signed(exp_item.mean), res_mean);
            err_count++;
          end
          if (res_slope !== exp_item.slope) begin
            if (err_count < REPORT_LIMIT)
              $error("res_slope: expected %0d, got %0d", $signed(exp_item.slope), res_slope);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    int sent;
    int line_len;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = dgds_pkg::CFG_SCHEME;
    cfg_data = '0;
    in_valid = 1'b0;
    coef_mean = '0;
    coef_slope = '0;
    line_start = 1'b0;
    win_mean[0] = '0;
    win_mean[1] = '0;
    win_slope[0] = '0;
    win_slope[1] = '0;
    win_fill = 0;
    pred_scheme = '0;
    pred_gain = '0;
    pred_only_inc = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].a);
      end else begin
        send_cell(directed_rows[i].a, directed_rows[i].b, directed_rows[i].ls,
                  directed_rows[i].typed, directed_rows[i].em, directed_rows[i].es);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(dgds_pkg::CFG_SCHEME, 32'(p % 4));
      write_reg(dgds_pkg::CFG_GAIN, phase_gain(p));
      write_reg(dgds_pkg::CFG_ONLY_INC, 32'(p / 4));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 58; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < PHASE_CELLS) begin
        line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
        for (int c = 0; c < line_len; c++) begin
          // A stray line start now and then cuts a line short.
          send_cell(pick_coef(), pick_coef(), c == 0 || $urandom_range(0, 99) < 3);
          sent++;
          // Long receiver hold while cells keep coming, so the input backs up.
          if (p == 0 && sent == 40) hold_left = LONG_HOLD;
          if (p == 1 && sent == 100) begin
            in_valid <= 1'b0;
            do @(negedge clk); while (pending_results.size() != 0);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dgds_pkg.sv
hw/rtl/dgds_ctrl.sv
hw/rtl/dgds_datapath.sv
hw/rtl/dg_diffusion_stencil_1d.sv
tb/tb_top.sv
